[hdl/rrds_pkg.sv]
package rrds_pkg;

  localparam int DRIVE_COUNT_DEF = 4;
  localparam int MASK_DRIVES     = 4;

  localparam logic [2:0] ST_STOP      = 3'd0;
  localparam logic [2:0] ST_WAIT_UP   = 3'd1;
  localparam logic [2:0] ST_MOVE_UP   = 3'd2;
  localparam logic [2:0] ST_STOP_UP   = 3'd3;
  localparam logic [2:0] ST_WAIT_DOWN = 3'd4;
  localparam logic [2:0] ST_MOVE_DOWN = 3'd5;
  localparam logic [2:0] ST_STOP_DOWN = 3'd6;
  localparam logic [2:0] ST_MAX       = 3'd6;

  localparam logic [1:0] DIR_STOPPED = 2'd0;
  localparam logic [1:0] DIR_UP      = 2'd1;
  localparam logic [1:0] DIR_DOWN    = 2'd2;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;

  localparam logic [2:0] REG_STATE_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_INRUSH_RELOAD = 3'd1;
  localparam logic [2:0] REG_SS_ENABLE     = 3'd2;
  localparam logic [2:0] REG_SS_ADD        = 3'd3;
  localparam logic [2:0] REG_SS_LIMIT      = 3'd4;
  localparam logic [2:0] REG_LIMIT_AWARE   = 3'd5;

  localparam logic [7:0]  STATE_TIMEOUT_DEF = 8'd10;
  localparam logic [7:0]  INRUSH_RELOAD_DEF = 8'd10;
  localparam logic        SS_ENABLE_DEF     = 1'b1;
  localparam logic [11:0] SS_ADD_DEF        = 12'(7 * 100);
  localparam logic [15:0] SS_LIMIT_DEF      = 16'(40 * 100);
  localparam logic        LIMIT_AWARE_DEF   = 1'b0;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  state_timeout;
    logic [7:0]  inrush_reload;
    logic        ss_enable;
    logic [11:0] ss_add;
    logic [15:0] ss_limit;
    logic        limit_aware;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [7:0]  stimer;
    logic [7:0]  inrush;
    logic [15:0] budget;
    logic [1:0]  dir;
  } drive_rec_t;

  typedef struct packed {
    logic accept;
    logic visit;
    logic load_out;
  } seq_ctl_t;

  function automatic logic [2:0] clean_state(input logic [2:0] s);
    return (s > ST_MAX) ? ST_STOP : s;
  endfunction

  function automatic logic [2:0] up_next(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      ST_STOP:      r = ST_MOVE_UP;
      ST_WAIT_UP:   r = ST_WAIT_UP;
      ST_MOVE_UP:   r = ST_MOVE_UP;
      ST_STOP_UP:   r = ST_MOVE_UP;
      ST_WAIT_DOWN: r = ST_MOVE_UP;
      ST_MOVE_DOWN: r = ST_WAIT_UP;
      ST_STOP_DOWN: r = ST_WAIT_UP;
      default:      r = ST_MOVE_UP;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] stop_next(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      ST_STOP:      r = ST_STOP;
      ST_WAIT_UP:   r = ST_STOP_DOWN;
      ST_MOVE_UP:   r = ST_STOP_UP;
      ST_STOP_UP:   r = ST_STOP_UP;
      ST_WAIT_DOWN: r = ST_STOP_UP;
      ST_MOVE_DOWN: r = ST_STOP_DOWN;
      ST_STOP_DOWN: r = ST_STOP_DOWN;
      default:      r = ST_STOP;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] down_next(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      ST_STOP:      r = ST_MOVE_DOWN;
      ST_WAIT_UP:   r = ST_MOVE_DOWN;
      ST_MOVE_UP:   r = ST_WAIT_DOWN;
      ST_STOP_UP:   r = ST_WAIT_DOWN;
      ST_WAIT_DOWN: r = ST_WAIT_DOWN;
      ST_MOVE_DOWN: r = ST_MOVE_DOWN;
      ST_STOP_DOWN: r = ST_MOVE_DOWN;
      default:      r = ST_MOVE_DOWN;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] timeout_next(input logic [2:0] s);
    logic [2:0] r;
    case (s)
      ST_STOP:      r = ST_STOP;
      ST_WAIT_UP:   r = ST_MOVE_UP;
      ST_MOVE_UP:   r = ST_MOVE_UP;
      ST_STOP_UP:   r = ST_STOP;
      ST_WAIT_DOWN: r = ST_MOVE_DOWN;
      ST_MOVE_DOWN: r = ST_MOVE_DOWN;
      ST_STOP_DOWN: r = ST_STOP;
      default:      r = ST_STOP;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_of(input logic [2:0] s);
    logic [1:0] r;
    case (s)
      ST_STOP:      r = DIR_STOPPED;
      ST_WAIT_UP:   r = DIR_DOWN;
      ST_MOVE_UP:   r = DIR_UP;
      ST_STOP_UP:   r = DIR_UP;
      ST_WAIT_DOWN: r = DIR_UP;
      ST_MOVE_DOWN: r = DIR_DOWN;
      ST_STOP_DOWN: r = DIR_DOWN;
      default:      r = DIR_STOPPED;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] budget_add(input logic [15:0] b, input logic [11:0] a);
    logic [16:0] sum;
    sum = {1'b0, b} + 17'(a);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage

[hdl/rrds_unit.sv]
module rrds_unit
  import rrds_pkg::*;
(
  input  logic [1:0]  op,
  input  logic        req_nz,
  input  cfg_t        cfg,
  input  drive_rec_t  rec_i,
  output drive_rec_t  rec_o
);

  logic [2:0]  cur;
  logic [2:0]  nxt;
  logic [2:0]  mv;
  logic        allowed;
  logic [15:0] bud;

  always_comb begin
    rec_o   = rec_i;
    cur     = clean_state(rec_i.state);
    nxt     = cur;
    mv      = (op == OP_UP) ? ST_MOVE_UP : ST_MOVE_DOWN;
    allowed = !cfg.ss_enable || (rec_i.budget <= cfg.ss_limit) || (cur == mv);
    bud     = rec_i.budget;
    case (op)
      OP_TICK: begin
        if (rec_i.inrush != 8'd0) begin
          rec_o.inrush = rec_i.inrush - 8'd1;
        end
        if (rec_i.stimer != 8'd0) begin
          rec_o.stimer = rec_i.stimer - 8'd1;
        end else begin
          nxt         = timeout_next(cur);
          rec_o.state = nxt;
          if (nxt != cur) begin
            rec_o.inrush = cfg.inrush_reload;
            if (cfg.ss_enable && (cur == ST_MOVE_UP || cur == ST_MOVE_DOWN)) begin
              bud = budget_add(bud, cfg.ss_add);
            end
          end
        end
        rec_o.dir = dir_of(clean_state(rec_o.state));
        if (bud != 16'd0) begin
          bud = bud - 16'd1;
        end
        rec_o.budget = bud;
      end
      OP_UP, OP_DOWN: begin
        if (req_nz && allowed) begin
          nxt = (op == OP_UP) ? up_next(cur) : down_next(cur);
          if (nxt != cur) begin
            rec_o.inrush = cfg.inrush_reload;
            if (nxt == mv && cfg.ss_enable) begin
              rec_o.budget = budget_add(bud, cfg.ss_add);
            end
          end
        end else begin
          nxt = stop_next(cur);
        end
        if (rec_i.state != nxt) begin
          rec_o.stimer = cfg.state_timeout;
        end
        rec_o.state = nxt;
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

[hdl/rrds_seq.sv]
module rrds_seq
  import rrds_pkg::*;
#(
  parameter int DRIVE_COUNT = DRIVE_COUNT_DEF,
  localparam int PTR_W = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             is_tick,
  input  logic             idx_ok,
  input  logic [PTR_W-1:0] idx_ptr,
  input  logic             out_blocked,
  output seq_ctl_t         ctl,
  output logic [PTR_W-1:0] ptr
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DRIVE_COUNT - 1);

  seq_state_t       state_r, state_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             tick_r, tick_nxt;
  logic             accept;

  assign accept = in_valid && !in_stall;
  assign ptr    = ptr_r;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    tick_nxt  = tick_r;
    case (state_r)
      SEQ_IDLE: begin
        if (accept) begin
          tick_nxt = is_tick;
          if (is_tick) begin
            state_nxt = SEQ_RUN;
            ptr_nxt   = '0;
          end else if (idx_ok) begin
            state_nxt = SEQ_RUN;
            ptr_nxt   = idx_ptr;
          end else begin
            state_nxt = SEQ_DONE;
          end
        end
      end
      SEQ_RUN: begin
        if (tick_r && ptr_r != LAST_PTR) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end else begin
          state_nxt = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (!out_blocked) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != SEQ_IDLE);
    ctl.accept   = in_valid && (state_r == SEQ_IDLE);
    ctl.visit    = (state_r == SEQ_RUN);
    ctl.load_out = (state_r == SEQ_DONE) && !out_blocked;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      ptr_r   <= '0;
      tick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

[hdl/reversing_relay_drive_sequencer.sv]
// A tick updates every drive in turn, a request updates only the addressed drive, and a
// request for an absent drive updates none; the result is registered once the updates are done.
// One drive record is updated per cycle by the single shared update unit. No new item is
// accepted until the result has been loaded, which waits while the output is stalled.
// Synchronous active-low reset stops every drive, clears all timers, budgets and
// directions, and restores the configuration registers to their defaults.
module reversing_relay_drive_sequencer
  import rrds_pkg::*;
#(
  parameter int DRIVE_COUNT = DRIVE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_drive_index,
  input  logic [7:0]  in_drive_request,
  input  logic [3:0]  in_lower_limit_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_up_relays,
  output logic [3:0]  out_down_relays,
  output logic [7:0]  out_direction_bits,
  output logic [3:0]  out_inrush_active,
  output logic [2:0]  out_addressed_state,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PTR_W  = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;
  localparam int MASK_N = (DRIVE_COUNT < MASK_DRIVES) ? DRIVE_COUNT : MASK_DRIVES;

  cfg_t       cfg_r;
  drive_rec_t drv_r [DRIVE_COUNT];
  drive_rec_t rec_new;

  logic [1:0] op_r;
  logic [1:0] idx_r;
  logic       idx_ok_r;
  logic       req_nz_r;
  logic [3:0] lim_r;
  logic [2:0] addr_r;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] up_r, down_r, inr_act_r;
  logic [7:0] dir_bits_r;
  logic [2:0] addr_out_r;

  logic [3:0] up_m, down_m, inr_m;
  logic [7:0] dir_m;

  seq_ctl_t         ctl;
  logic [PTR_W-1:0] ptr;
  logic             idx_ok;
  logic             out_blocked;

  assign cfg_ready   = 1'b1;
  assign idx_ok      = (32'(in_drive_index) < DRIVE_COUNT);
  assign out_blocked = out_valid_r && out_stall;

  rrds_seq #(
    .DRIVE_COUNT(DRIVE_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .is_tick    (in_operation == OP_TICK),
    .idx_ok     (idx_ok),
    .idx_ptr    (PTR_W'(in_drive_index)),
    .out_blocked(out_blocked),
    .ctl        (ctl),
    .ptr        (ptr)
  );

  rrds_unit u_unit (
    .op    (op_r),
    .req_nz(req_nz_r),
    .cfg   (cfg_r),
    .rec_i (drv_r[ptr]),
    .rec_o (rec_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.state_timeout <= STATE_TIMEOUT_DEF;
      cfg_r.inrush_reload <= INRUSH_RELOAD_DEF;
      cfg_r.ss_enable     <= SS_ENABLE_DEF;
      cfg_r.ss_add        <= SS_ADD_DEF;
      cfg_r.ss_limit      <= SS_LIMIT_DEF;
      cfg_r.limit_aware   <= LIMIT_AWARE_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STATE_TIMEOUT: cfg_r.state_timeout <= cfg_data[7:0];
        REG_INRUSH_RELOAD: cfg_r.inrush_reload <= cfg_data[7:0];
        REG_SS_ENABLE:     cfg_r.ss_enable     <= cfg_data[0];
        REG_SS_ADD:        cfg_r.ss_add        <= cfg_data[11:0];
        REG_SS_LIMIT:      cfg_r.ss_limit      <= cfg_data;
        REG_LIMIT_AWARE:   cfg_r.limit_aware   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DRIVE_COUNT; d++) begin
        drv_r[d] <= '{state: ST_STOP, stimer: 8'd0, inrush: 8'd0, budget: 16'd0,
                      dir: DIR_STOPPED};
      end
    end else if (ctl.visit) begin
      drv_r[ptr] <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r     <= in_operation;
      idx_r    <= in_drive_index;
      idx_ok_r <= idx_ok;
      req_nz_r <= (in_drive_request != 8'd0);
      lim_r    <= in_lower_limit_bits;
      addr_r   <= ST_STOP;
    end else if (ctl.visit && idx_ok_r && ptr == PTR_W'(idx_r)) begin
      addr_r <= rec_new.state;
    end
  end

  for (genvar g = 0; g < MASK_DRIVES; g++) begin : g_mask
    if (g < MASK_N) begin : g_live
      logic [2:0] s;
      logic       brake;
      assign s     = clean_state(drv_r[g].state);
      assign brake = (s == ST_WAIT_UP || s == ST_STOP_DOWN)
                     && (!cfg_r.limit_aware || lim_r[g]);
      assign up_m[g]           = (s == ST_MOVE_UP) || brake;
      assign down_m[g]         = (s == ST_MOVE_DOWN) || brake;
      assign inr_m[g]          = (drv_r[g].inrush != 8'd0);
      assign dir_m[2*g +: 2]   = drv_r[g].dir;
    end else begin : g_none
      assign up_m[g]         = 1'b0;
      assign down_m[g]       = 1'b0;
      assign inr_m[g]        = 1'b0;
      assign dir_m[2*g +: 2] = DIR_STOPPED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      up_r       <= up_m;
      down_r     <= down_m;
      dir_bits_r <= dir_m;
      inr_act_r  <= inr_m;
      addr_out_r <= addr_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_up_relays       = up_r;
  assign out_down_relays     = down_r;
  assign out_direction_bits  = dir_bits_r;
  assign out_inrush_active   = inr_act_r;
  assign out_addressed_state = addr_out_r;

endmodule

[hdl/rrds_check.sv]
module rrds_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_up_relays,
  input logic [3:0]  out_down_relays,
  input logic [7:0]  out_direction_bits,
  input logic [3:0]  out_inrush_active,
  input logic [2:0]  out_addressed_state
);

  // Once an input transaction is taken, the block is busy in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while the previous item was still in progress");

  // A result is only ever produced by an item that was in progress.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result offered without an item in progress");

  // A result cannot be offered in the same cycle as its own input transaction.
  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && in_valid && !in_stall) |=> !(out_valid && !$past(in_stall)))
    else $error("result offered without processing time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_up_relays)
      && $stable(out_down_relays) && $stable(out_direction_bits)
      && $stable(out_inrush_active) && $stable(out_addressed_state)))
    else $error("stalled result transaction changed or was dropped");

endmodule

bind reversing_relay_drive_sequencer rrds_check u_rrds_check (.*);
